@@ rtl/lsrs_pkg.sv @@
// Shared constants and types for the log-structured register store.
package lsrs_pkg;

	// Parameter defaults
	localparam int MAX_REGS_DEF   = 64;
	localparam int BANK_DEPTH_DEF = 256;
	localparam int BLOCK_BITS_DEF = 64;

	// Fixed port widths
	localparam int DATA_W    = 64;
	localparam int RIDX_W    = 6;
	localparam int RCNT_W    = 7;
	localparam int ABLK_W    = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REG_COUNT    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_BLOCKS = 4'd1;

	// Configuration reset values
	localparam logic [RCNT_W-1:0] REG_COUNT_RST    = 7'd16;
	localparam logic [ABLK_W-1:0] ARRAY_BLOCKS_RST = 9'd256;

	// Command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_CFG   = 2'd2
	} status_t;

endpackage

@@ rtl/lsrs_ram.sv @@
// Generic simple dual-port RAM, one write port, one registered read port.
module lsrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/log_structured_register_store.sv @@
// Log-structured register store: map RAM, two-bank block RAM, compaction sequencer.
//
//  channel   signals                                  direction  handshake
//  command   start, busy, cmd, reg_index, write_data  in         start & !busy
//  result    done, read_data, status, compacted       out        done strobe, one cycle
//  config    cfg_we, cfg_index, cfg_data              in         cfg_we, no wait
//
// Reads and writes each do a map RAM lookup, then one block RAM access; errors end
// after the lookup. A write that finds the active bank full first compacts, one
// register per cycle through the map and block RAMs.
// After reset and after every write to a configuration register both RAMs are swept
// to zero, with busy high.
// Results cannot be held off; done pulses for exactly one cycle per transaction.
module log_structured_register_store
	import lsrs_pkg::*;
#(
	parameter int MAX_REGS   = MAX_REGS_DEF,
	parameter int BANK_DEPTH = BANK_DEPTH_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cmd,
	input  logic [RIDX_W-1:0]    reg_index,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 done,
	output logic [DATA_W-1:0]    read_data,
	output logic [1:0]           status,
	output logic                 compacted,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int MAW   = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int OW    = $clog2(BANK_DEPTH);
	localparam int FW    = OW + 1;
	localparam int SDEP  = 2 * BANK_DEPTH;
	localparam int SAW   = $clog2(SDEP);
	localparam int CLR_N = (SDEP > MAX_REGS) ? SDEP : MAX_REGS;
	localparam int CW    = $clog2(CLR_N);

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_LOOKUP  = 7'b0000100,
		S_RDATA   = 7'b0001000,
		S_COMPACT = 7'b0010000,
		S_DRAIN   = 7'b0100000,
		S_APPEND  = 7'b1000000
	} state_t;

	function automatic logic [SAW-1:0] saddr(input logic bank, input logic [OW-1:0] off);
		logic [SAW-1:0] o;
		o = SAW'(off);
		return bank ? (SAW'(BANK_DEPTH) + o) : o;
	endfunction

	state_t               state_q;
	logic [CW-1:0]        clr_cnt_q;
	logic [RCNT_W-1:0]    reg_count_q;
	logic [ABLK_W-1:0]    array_blocks_q;
	logic                 bank_q;
	logic [FW-1:0]        free_q;
	logic [RCNT_W-1:0]    cp_idx_q;
	logic                 v_s1, v_s2;
	logic [RCNT_W-1:0]    idx_s1, idx_s2;

	logic                 cmd_q;
	logic [RIDX_W-1:0]    ridx_q;
	logic [BLOCK_BITS-1:0] data_q;
	status_t              err_q;

	logic                 done_q;
	logic [BLOCK_BITS-1:0] rdata_q;
	status_t              status_q;
	logic                 comp_q;

	// RAM ports
	logic                  map_we;
	logic [MAW-1:0]        map_waddr, map_raddr;
	logic [OW-1:0]         map_wdata, map_rdata;
	logic                  st_we;
	logic [SAW-1:0]        st_waddr, st_raddr;
	logic [BLOCK_BITS-1:0] st_wdata, st_rdata;

	logic        accept, cfg_ok, cfg_hit, need_comp, cp_issue;
	logic        clr_we, lk_we, ap_we;
	logic [31:0] clr_w, ridx_w, rin_w, cp_w, idx2_w;
	status_t     err_in;

	assign cfg_ok = (32'(reg_count_q) < 32'(array_blocks_q)) &&
	                (32'(reg_count_q) <= 32'(MAX_REGS)) &&
	                (array_blocks_q >= ABLK_W'(2)) &&
	                (32'(array_blocks_q) <= 32'(BANK_DEPTH));

	assign busy      = !(state_q == S_IDLE || state_q == S_RDATA);
	assign accept    = start && !busy;
	assign cfg_hit   = cfg_we && (cfg_index == CFG_REG_COUNT || cfg_index == CFG_ARRAY_BLOCKS);
	assign need_comp = 32'(free_q) >= 32'(array_blocks_q);
	assign cp_issue  = (state_q == S_COMPACT) && (cp_idx_q < reg_count_q);

	assign clr_w  = 32'(clr_cnt_q);
	assign ridx_w = 32'(ridx_q);
	assign rin_w  = 32'(reg_index);
	assign cp_w   = 32'(cp_idx_q);
	assign idx2_w = 32'(idx_s2);

	always_comb begin
		if (!cfg_ok) begin
			err_in = ST_CFG;
		end else if (RCNT_W'(reg_index) >= reg_count_q) begin
			err_in = ST_RANGE;
		end else begin
			err_in = ST_OK;
		end
	end

	assign clr_we = (state_q == S_CLEAR);
	assign lk_we  = (state_q == S_LOOKUP) && (err_q == ST_OK) && (cmd_q == CMD_WRITE) &&
	                !need_comp;
	assign ap_we  = (state_q == S_APPEND);

	// map RAM ports
	always_comb begin
		map_we    = 1'b0;
		map_waddr = ridx_w[MAW-1:0];
		map_wdata = free_q[OW-1:0];
		if (clr_we) begin
			map_we    = clr_w < 32'(MAX_REGS);
			map_waddr = clr_w[MAW-1:0];
			map_wdata = '0;
		end else if (lk_we) begin
			map_we = 1'b1;
		end else if (v_s2) begin
			map_we    = 1'b1;
			map_waddr = idx2_w[MAW-1:0];
			map_wdata = OW'(idx_s2);
		end else if (ap_we) begin
			map_we    = 1'b1;
			map_wdata = OW'(reg_count_q);
		end
		map_raddr = (state_q == S_COMPACT) ? cp_w[MAW-1:0] : rin_w[MAW-1:0];
	end

	// block RAM ports
	always_comb begin
		st_we    = 1'b0;
		st_waddr = saddr(bank_q, free_q[OW-1:0]);
		st_wdata = data_q;
		if (clr_we) begin
			st_we    = clr_w < 32'(SDEP);
			st_waddr = clr_w[SAW-1:0];
			st_wdata = '0;
		end else if (lk_we) begin
			st_we = 1'b1;
		end else if (v_s2) begin
			// compaction copy lands in the other bank
			st_we    = 1'b1;
			st_waddr = saddr(!bank_q, OW'(idx_s2));
			st_wdata = st_rdata;
		end else if (ap_we) begin
			st_we    = 1'b1;
			st_waddr = saddr(!bank_q, OW'(reg_count_q));
		end
		st_raddr = saddr(bank_q, map_rdata);
	end

	lsrs_ram #(.WIDTH(OW), .DEPTH(MAX_REGS), .AW(MAW)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	lsrs_ram #(.WIDTH(BLOCK_BITS), .DEPTH(SDEP), .AW(SAW)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clr_cnt_q      <= '0;
			reg_count_q    <= REG_COUNT_RST;
			array_blocks_q <= ARRAY_BLOCKS_RST;
			bank_q         <= 1'b0;
			free_q         <= '0;
			cp_idx_q       <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= cp_issue;
			v_s2   <= v_s1;
			case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + CW'(1);
					if (clr_cnt_q == CW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (err_q != ST_OK) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (cmd_q == CMD_READ) begin
						state_q <= S_RDATA;
					end else if (need_comp) begin
						cp_idx_q <= '0;
						state_q  <= S_COMPACT;
					end else begin
						free_q  <= free_q + FW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RDATA: begin
					done_q  <= 1'b1;
					state_q <= accept ? S_LOOKUP : S_IDLE;
				end
				S_COMPACT: begin
					if (cp_issue) begin
						cp_idx_q <= cp_idx_q + RCNT_W'(1);
					end else begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					bank_q  <= !bank_q;
					free_q  <= FW'(reg_count_q) + FW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			// configuration register write restarts the clearing sweep and resets bank and free pointer
			if (cfg_hit) begin
				if (cfg_index == CFG_REG_COUNT) begin
					reg_count_q <= cfg_data[RCNT_W-1:0];
				end else begin
					array_blocks_q <= cfg_data[ABLK_W-1:0];
				end
				state_q   <= S_CLEAR;
				clr_cnt_q <= '0;
				bank_q    <= 1'b0;
				free_q    <= '0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= cp_idx_q;
		idx_s2 <= idx_s1;
		if (accept) begin
			cmd_q  <= cmd;
			ridx_q <= reg_index;
			data_q <= write_data[BLOCK_BITS-1:0];
			err_q  <= err_in;
		end
		case (state_q)
			S_LOOKUP: begin
				rdata_q  <= '0;
				status_q <= err_q;
				comp_q   <= 1'b0;
			end
			S_RDATA: begin
				rdata_q  <= st_rdata;
				status_q <= ST_OK;
				comp_q   <= 1'b0;
			end
			S_APPEND: begin
				rdata_q  <= '0;
				status_q <= ST_OK;
				comp_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign read_data = DATA_W'(rdata_q);
	assign status    = status_q;
	assign compacted = comp_q;

`ifndef SYNTHESIS
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> busy)
		else $error("transaction accepted during clearing sweep");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({clr_we, lk_we, v_s2, ap_we}))
		else $error("block RAM write port claimed twice");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cfg_ok) |-> (32'(free_q) <= 32'(array_blocks_q)))
		else $error("free pointer past end of bank");

	a_comp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && comp_q) |-> (status_q == ST_OK))
		else $error("compaction reported with error status");
`endif

endmodule

@@ tb/sv/tb_log_structured_register_store.sv @@
// Testbench for the log-structured register store: directed and random command traffic.
module tb_log_structured_register_store
	import lsrs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_SHOWN   = 200;
	// config indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

	typedef struct {
		logic              op;
		logic [RIDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
	} cmd_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		status_t           stat;
		logic              comp;
	} outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 cmd = CMD_READ;
	logic [RIDX_W-1:0]    reg_index = '0;
	logic [DATA_W-1:0]    write_data = '0;
	logic                 done;
	logic [DATA_W-1:0]    read_data;
	logic [1:0]           status;
	logic                 compacted;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	cmd_item_t   pending_cmds[$];
	outcome_t    awaited_results[$];
	bit          item_taken = 0;
	int unsigned idle_pct = 30;
	int unsigned write_pct = 55;
	int          err_count = 0;
	int          quiet_cycles = 0;

	// shadow of the block
	int unsigned       cfg_regs;
	int unsigned       cfg_blocks;
	int unsigned       log_slot[MAX_REGS_DEF];
	int unsigned       next_free;
	int unsigned       live_bank;
	logic [DATA_W-1:0] log_mem[2*BANK_DEPTH_DEF];

	log_structured_register_store uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.reg_index(reg_index),
		.write_data(write_data),
		.done(done),
		.read_data(read_data),
		.status(status),
		.compacted(compacted),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5ns clk = ~clk;

	function automatic int unsigned mem_addr(input int unsigned bank, input int unsigned off);
		return (bank & 1) * BANK_DEPTH_DEF + (off < BANK_DEPTH_DEF ? off : 0);
	endfunction

	function automatic void clear_log();
		foreach (log_slot[i]) log_slot[i] = 0;
		foreach (log_mem[i]) log_mem[i] = '0;
		next_free = 0;
		live_bank = 0;
	endfunction

	function automatic void shadow_cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		if (idx == CFG_REG_COUNT) begin
			cfg_regs = val[RCNT_W-1:0];
		end else if (idx == CFG_ARRAY_BLOCKS) begin
			cfg_blocks = val;
		end else begin
			return;
		end
		clear_log();
	endfunction

	// Expected outcome of one command; updates the shadow log on a good write.
	function automatic outcome_t log_outcome(input logic op, input logic [RIDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		outcome_t    r;
		int unsigned nb;
		r.rdata = '0;
		r.stat  = ST_OK;
		r.comp  = 1'b0;
		if (cfg_regs >= cfg_blocks || cfg_regs > MAX_REGS_DEF || cfg_blocks < 2 ||
				cfg_blocks > BANK_DEPTH_DEF) begin
			r.stat = ST_CFG;
		end else if (idx >= cfg_regs) begin
			r.stat = ST_RANGE;
		end else if (op == CMD_READ) begin
			r.rdata = log_mem[mem_addr(live_bank, log_slot[idx])];
		end else begin
			if (next_free >= cfg_blocks) begin
				// bank full: move live blocks in register order to the other bank
				nb = live_bank ^ 1;
				for (int i = 0; i < cfg_regs; i++) begin
					log_mem[mem_addr(nb, i)] = log_mem[mem_addr(live_bank, log_slot[i])];
					log_slot[i] = i;
				end
				live_bank = nb;
				next_free = cfg_regs;
				r.comp = 1'b1;
			end
			log_mem[mem_addr(live_bank, next_free)] = data;
			log_slot[idx] = next_free;
			next_free++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_SHOWN)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic queue_item(input logic op, input logic [RIDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		cmd_item_t it;
		it.op   = op;
		it.idx  = idx;
		it.data = data;
		pending_cmds.push_back(it);
	endtask

	task automatic drain();
		while (pending_cmds.size() != 0 || awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		shadow_cfg_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [CFG_W-1:0] rc_word, input logic [CFG_W-1:0] ab_word);
		drain();
		cfg_write(CFG_REG_COUNT, rc_word);
		cfg_write(CFG_ARRAY_BLOCKS, ab_word);
		repeat (2) @(negedge clk);
	endtask

	task automatic random_batch(input int n);
		logic              op;
		logic [RIDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
		int unsigned       pick;
		// first a read: a fresh configuration must read back as cleared
		queue_item(CMD_READ, '0, '0);
		for (int k = 0; k < n; k++) begin
			op   = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_READ;
			pick = $urandom_range(99);
			if (cfg_regs > 0 && cfg_regs < MAX_REGS_DEF && pick >= 10)
				idx = $urandom_range(cfg_regs - 1, 0);
			else if (cfg_regs > 0 && cfg_regs < MAX_REGS_DEF)
				idx = $urandom_range(MAX_REGS_DEF - 1, cfg_regs);
			else
				idx = $urandom_range(MAX_REGS_DEF - 1, 0);
			case ($urandom_range(9))
				0: data = '0;
				1: data = '1;
				default: data = {$urandom, $urandom};
			endcase
			queue_item(op, idx, data);
		end
	endtask

	// accept at the rising edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			awaited_results.push_back(log_outcome(cmd, reg_index, write_data));
			void'(pending_cmds.pop_front());
			item_taken = 1;
		end
	end

	// command driver
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			// hold until taken
		end else begin
			item_taken = 0;
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start      <= 1'b1;
				cmd        <= pending_cmds[0].op;
				reg_index  <= pending_cmds[0].idx;
				write_data <= pending_cmds[0].data;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		outcome_t exp_r;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with no transaction outstanding");
			end else begin
				exp_r = awaited_results.pop_front();
				if (read_data !== exp_r.rdata)
					report_mismatch($sformatf("read_data got %h want %h", read_data,
						exp_r.rdata));
				if (status !== exp_r.stat)
					report_mismatch($sformatf("status got %0d want %0d", status, exp_r.stat));
				if (compacted !== exp_r.comp)
					report_mismatch($sformatf("compacted got %b want %b", compacted,
						exp_r.comp));
			end
		end
		if ((start && !busy) || done || cfg_we || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		cfg_regs   = REG_COUNT_RST;
		cfg_blocks = ARRAY_BLOCKS_RST;
		clear_log();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed, reset configuration (16 registers, 256 slots)
		queue_item(CMD_READ, 6'd0, '0);
		queue_item(CMD_READ, 6'd15, '0);
		queue_item(CMD_WRITE, 6'd0, 64'h0123_4567_89ab_cdef);
		queue_item(CMD_READ, 6'd1, '0);                     // unwritten: slot 0
		queue_item(CMD_WRITE, 6'd15, '1);
		queue_item(CMD_WRITE, 6'd7, 64'h8000_0000_0000_0001);
		queue_item(CMD_READ, 6'd15, '0);
		queue_item(CMD_READ, 6'd7, '0);
		queue_item(CMD_WRITE, 6'd0, '0);
		queue_item(CMD_READ, 6'd0, '0);
		queue_item(CMD_READ, 6'd16, '0);
		queue_item(CMD_WRITE, 6'd16, '1);
		queue_item(CMD_READ, 6'd63, '0);
		queue_item(CMD_WRITE, 6'd63, '1);
		queue_item(CMD_WRITE, 6'd3, 64'h5555_5555_5555_5555);
		queue_item(CMD_READ, 6'd3, '0);
		queue_item(CMD_WRITE, 6'd3, 64'haaaa_aaaa_aaaa_aaaa);
		queue_item(CMD_READ, 6'd3, '0);
		queue_item(CMD_READ, 6'd2, '0);
		queue_item(CMD_READ, 6'd15, '0);
		drain();
		random_batch(150);

		set_config(9'd1, 9'd2);     // compaction on nearly every write
		random_batch(120);
		set_config(9'd3, 9'd4);
		random_batch(100);
		drain();
		cfg_write(CFG_IDX_SPARE_HI, 9'h1ff);   // no such register: state kept
		repeat (2) @(negedge clk);
		random_batch(20);

		idle_pct = 51;
		set_config(9'd64, 9'd65);
		random_batch(200);
		// illegal settings
		set_config(9'd10, 9'd10);
		random_batch(10);
		set_config(9'h1ff, 9'd256);
		random_batch(8);
		set_config(9'd5, 9'd0);
		random_batch(6);
		set_config(9'd5, 9'd1);
		random_batch(6);
		set_config(9'd5, 9'd257);
		random_batch(6);
		set_config(9'd5, 9'h1ff);
		random_batch(6);
		set_config(9'd65, 9'd256);
		random_batch(6);
		set_config(9'd0, 9'd2);     // legal, but every index is out of range
		random_batch(8);

		idle_pct = 0;
		set_config(9'h105, 9'd8);   // upper bits dropped: 5 registers
		random_batch(150);
		set_config(9'd64, 9'd256);
		random_batch(150);
		set_config(9'd16, 9'd256);
		write_pct = 80;             // enough writes to fill a full bank
		random_batch(350);
		drain();
		cfg_write(CFG_IDX_SPARE_LO, 9'h000);
		repeat (2) @(negedge clk);
		random_batch(20);

		drain();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/lsrs_pkg.sv
rtl/lsrs_ram.sv
rtl/log_structured_register_store.sv
tb/sv/tb_log_structured_register_store.sv
